>>> sv/uqm_pkg.sv
// Shared types and constants for the uniform quantizer with MSE statistics.
// No dependencies; every other file imports this package.
`default_nettype none

package uqm_pkg;

   localparam int unsigned DATA_BITS      = 16;
   localparam int unsigned PIXEL_BITS     = 16;
   localparam int unsigned COUNT_BITS     = 20;
   localparam int unsigned CNT_W          = COUNT_BITS + 1;
   localparam int unsigned SUM_BITS       = 52;
   localparam int unsigned SQ_BITS        = 2 * DATA_BITS;
   localparam int unsigned MSE_BITS       = 40;
   localparam int unsigned MSE_FRAC_BITS  = 8;
   localparam int unsigned DIV_NUM_BITS   = SUM_BITS + MSE_FRAC_BITS;
   localparam int unsigned DIV_CNT_BITS   = $clog2(DIV_NUM_BITS + 1);
   localparam int unsigned RECIP_BITS     = 2 * DATA_BITS + 1;
   localparam int unsigned RECIP_CNT_BITS = $clog2(RECIP_BITS + 1);
   localparam int unsigned PROD_BITS      = DATA_BITS + RECIP_BITS;
   localparam int unsigned FIFO_DEPTH     = 4;
   localparam int unsigned FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_FILL_BITS = $clog2(FIFO_DEPTH + 1);
   localparam int unsigned CSR_INDEX_BITS = 4;

   localparam logic [DATA_BITS:0]   PIXEL_LIMIT = (DATA_BITS + 1)'(1) << PIXEL_BITS;
   localparam logic [DATA_BITS-1:0] PIXEL_MASK  = DATA_BITS'(PIXEL_LIMIT - 1'b1);

   // 2^(2*DATA_BITS), dividend of the reciprocal
   localparam logic [RECIP_BITS-1:0] RECIP_ONE = RECIP_BITS'(1) << (2 * DATA_BITS);

   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_SCALE = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_LEVELS    = CSR_INDEX_BITS'(1);

   localparam logic [DATA_BITS-1:0] MAX_SCALE_RESET = DATA_BITS'(255);
   localparam logic [DATA_BITS-1:0] LEVELS_RESET    = DATA_BITS'(10);

   typedef enum logic [2:0] {
      CFG_LOAD_STEP,
      CFG_DIV_STEP,
      CFG_LOAD_RECIP,
      CFG_DIV_RECIP,
      CFG_IDLE
   } cfg_state_type;

   typedef struct packed {
      logic [DATA_BITS-1:0]  max_scale;
      logic [DATA_BITS-1:0]  levels;
      logic [DATA_BITS-1:0]  step;
      logic [RECIP_BITS-1:0] recip;
      logic                  step_zero;
   } cfg_type;

   typedef struct packed {
      logic [DATA_BITS-1:0] code;
      logic [DATA_BITS-1:0] recon;
      logic [DATA_BITS-1:0] abs_error;
      logic                 last;
      logic                 step_err;
   } q_item_type;

   typedef struct packed {
      logic [DATA_BITS-1:0] code;
      logic [DATA_BITS-1:0] reconstructed;
      logic [DATA_BITS-1:0] abs_error;
      logic [DATA_BITS-1:0] max_error;
      logic [MSE_BITS-1:0]  mse;
      logic                 image_done;
      logic                 step_error;
   } rsp_type;

endpackage

`default_nettype wire

>>> sv/uqm_intf.sv
// Channel interfaces: pixel request, result response and register write.
// Depends on uqm_pkg for field widths.
`default_nettype none

interface uqm_req_if import uqm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [DATA_BITS-1:0] pixel;
   logic                 last_pixel;

   modport source (output valid, output pixel, output last_pixel, input ready);
   modport sink   (input valid, input pixel, input last_pixel, output ready);
endinterface

interface uqm_rsp_if import uqm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [DATA_BITS-1:0] code;
   logic [DATA_BITS-1:0] reconstructed;
   logic [DATA_BITS-1:0] abs_error;
   logic [DATA_BITS-1:0] max_error;
   logic [MSE_BITS-1:0]  mse;
   logic                 image_done;
   logic                 step_error;

   modport source (output valid, output code, output reconstructed, output abs_error,
                   output max_error, output mse, output image_done, output step_error,
                   input ready);
   modport sink   (input valid, input code, input reconstructed, input abs_error,
                   input max_error, input mse, input image_done, input step_error,
                   output ready);
endinterface

interface uqm_csr_if import uqm_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [DATA_BITS-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> sv/uqm_cfg.sv
// Register file plus serial divider that derives step = max_scale/levels
// and its reciprocal floor(2^32/step). Depends on uqm_pkg, uqm_csr_if.
`default_nettype none

module uqm_cfg import uqm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   uqm_csr_if.sink csr_if,
   output cfg_type cfg,
   output logic    busy
);

   cfg_state_type state_ff, state_in;

   logic [DATA_BITS-1:0]      max_scale_ff;
   logic [DATA_BITS-1:0]      levels_ff;
   logic [DATA_BITS-1:0]      step_ff;
   logic [RECIP_BITS-1:0]     recip_ff;
   logic [RECIP_BITS-1:0]     num_ff, num_in;
   logic [DATA_BITS-1:0]      rem_ff, rem_in;
   logic [RECIP_CNT_BITS-1:0] cnt_ff;

   logic                  csr_write;
   logic                  div_load, div_run, cap_step, cap_recip, clr_step;
   logic [DATA_BITS-1:0]  den;
   logic [RECIP_BITS-1:0] load_num;
   logic [DATA_BITS:0]    shifted, diff;
   logic                  ge;

   assign csr_if.ready = 1'b1;
   assign csr_write    = csr_if.valid;

   // next state
   always_comb begin
      state_in = state_ff;
      if (csr_write) begin
         state_in = CFG_LOAD_STEP;
      end else begin
         unique case (state_ff)
            CFG_LOAD_STEP:  state_in = (levels_ff == '0) ? CFG_IDLE : CFG_DIV_STEP;
            CFG_DIV_STEP:   if (cnt_ff == '0) state_in = CFG_LOAD_RECIP;
            CFG_LOAD_RECIP: state_in = (step_ff == '0) ? CFG_IDLE : CFG_DIV_RECIP;
            CFG_DIV_RECIP:  if (cnt_ff == '0) state_in = CFG_IDLE;
            CFG_IDLE:       state_in = CFG_IDLE;
            default:        state_in = CFG_LOAD_STEP;
         endcase
      end
   end

   // state outputs
   always_comb begin
      div_load  = 1'b0;
      div_run   = 1'b0;
      cap_step  = 1'b0;
      cap_recip = 1'b0;
      clr_step  = 1'b0;
      den       = step_ff;
      load_num  = RECIP_ONE;
      busy      = 1'b1;
      unique case (state_ff)
         CFG_LOAD_STEP: begin
            div_load = 1'b1;
            load_num = RECIP_BITS'(max_scale_ff);
            clr_step = (levels_ff == '0);
         end
         CFG_DIV_STEP: begin
            den      = levels_ff;
            div_run  = (cnt_ff != '0);
            cap_step = (cnt_ff == '0);
         end
         CFG_LOAD_RECIP: begin
            div_load = 1'b1;
         end
         CFG_DIV_RECIP: begin
            div_run   = (cnt_ff != '0);
            cap_recip = (cnt_ff == '0);
         end
         CFG_IDLE: begin
            busy = 1'b0;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // one restoring shift-subtract step per cycle
   assign shifted = {rem_ff, num_ff[RECIP_BITS-1]};
   assign ge      = (shifted >= {1'b0, den});
   assign diff    = shifted - {1'b0, den};
   assign rem_in  = ge ? diff[DATA_BITS-1:0] : shifted[DATA_BITS-1:0];
   assign num_in  = {num_ff[RECIP_BITS-2:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CFG_LOAD_STEP;
         max_scale_ff <= MAX_SCALE_RESET;
         levels_ff    <= LEVELS_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            unique case (csr_if.index)
               REG_MAX_SCALE: max_scale_ff <= csr_if.data;
               REG_LEVELS:    levels_ff <= csr_if.data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_load) begin
         num_ff <= load_num;
         rem_ff <= '0;
         cnt_ff <= RECIP_CNT_BITS'(RECIP_BITS);
      end else if (div_run) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff - 1'b1;
      end
      if (clr_step) begin
         step_ff <= '0;
      end else if (cap_step) begin
         step_ff <= num_ff[DATA_BITS-1:0];
      end
      if (cap_recip) begin
         recip_ff <= num_ff;
      end
   end

   assign cfg.max_scale = max_scale_ff;
   assign cfg.levels    = levels_ff;
   assign cfg.step      = step_ff;
   assign cfg.recip     = recip_ff;
   assign cfg.step_zero = (step_ff == '0);

`ifndef ASSERT_OFF
   a_write_recomputes: assert property (@(posedge clock) disable iff (reset)
      csr_if.valid && csr_if.ready |=> busy)
      else $error("register write did not start step recomputation");
`endif

endmodule

`default_nettype wire

>>> sv/uqm_front.sv
// Front end: accepts pixels and quantizes them in a five-stage pipeline
// (reciprocal multiply, estimate*step, correct+clamp, code*step, recon+error).
// Depends on uqm_pkg and uqm_req_if; feeds uqm_fifo.
`default_nettype none

module uqm_front import uqm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   uqm_req_if.sink    req_if,
   input  cfg_type    cfg,
   input  logic       cfg_busy,
   input  logic       fifo_full,
   output logic       push,
   output q_item_type push_item
);

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic adv, accept;

   logic [DATA_BITS-1:0] pix1_ff, pix2_ff, pix3_ff, pix4_ff;
   logic                 last1_ff, last2_ff, last3_ff, last4_ff, last5_ff;
   logic                 se1_ff, se2_ff, se3_ff, se4_ff, se5_ff;
   logic [PROD_BITS-2:0] prod1_ff;
   logic [DATA_BITS-1:0] qe2_ff;
   logic [SQ_BITS-1:0]   qs2_ff;
   logic [DATA_BITS-1:0] code3_ff, code4_ff, code5_ff;
   logic [SQ_BITS-1:0]   mul4_ff;
   logic [DATA_BITS-1:0] recon5_ff, err5_ff;

   logic [DATA_BITS-1:0] pix_in;
   logic [PROD_BITS-1:0] prod_full;
   logic [DATA_BITS-1:0] qe2_in;
   logic [SQ_BITS-1:0]   qs2_in;
   logic [DATA_BITS-1:0] rem3, q3, lev_max, code3_in;
   logic [SQ_BITS-1:0]   mul4_in;
   logic [DATA_BITS-1:0] recon5_in, err5_in;

   // whole pipeline stalls only when the last stage cannot drain
   assign adv          = !v5_ff || !fifo_full;
   assign req_if.ready = adv && !cfg_busy;
   assign accept       = req_if.valid && req_if.ready;

   assign pix_in    = req_if.pixel & PIXEL_MASK;
   assign prod_full = PROD_BITS'(pix_in) * PROD_BITS'(cfg.recip);

   assign qe2_in = prod1_ff[PROD_BITS-2:2*DATA_BITS];
   assign qs2_in = SQ_BITS'(qe2_in) * SQ_BITS'(cfg.step);

   // estimate is low by at most one
   assign rem3    = pix2_ff - qs2_ff[DATA_BITS-1:0];
   assign q3      = qe2_ff + DATA_BITS'(rem3 >= cfg.step);
   assign lev_max = cfg.levels - 1'b1;

   always_comb begin
      priority if (pix2_ff == cfg.max_scale) begin
         code3_in = lev_max;
      end else if (q3 > lev_max) begin
         code3_in = lev_max;
      end else begin
         code3_in = q3;
      end
   end

   assign mul4_in   = SQ_BITS'(code3_ff) * SQ_BITS'(cfg.step);
   assign recon5_in = mul4_ff[DATA_BITS-1:0] + (cfg.step >> 1);
   assign err5_in   = (pix4_ff >= recon5_in) ? (pix4_ff - recon5_in) : (recon5_in - pix4_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pix1_ff   <= pix_in;
         last1_ff  <= req_if.last_pixel;
         se1_ff    <= cfg.step_zero;
         prod1_ff  <= prod_full[PROD_BITS-2:0];

         pix2_ff   <= pix1_ff;
         last2_ff  <= last1_ff;
         se2_ff    <= se1_ff;
         qe2_ff    <= qe2_in;
         qs2_ff    <= qs2_in;

         pix3_ff   <= pix2_ff;
         last3_ff  <= last2_ff;
         se3_ff    <= se2_ff;
         code3_ff  <= code3_in;

         pix4_ff   <= pix3_ff;
         last4_ff  <= last3_ff;
         se4_ff    <= se3_ff;
         code4_ff  <= code3_ff;
         mul4_ff   <= mul4_in;

         last5_ff  <= last4_ff;
         se5_ff    <= se4_ff;
         code5_ff  <= code4_ff;
         recon5_ff <= recon5_in;
         err5_ff   <= err5_in;
      end
   end

   assign push                = v5_ff && !fifo_full;
   assign push_item.code      = code5_ff;
   assign push_item.recon     = recon5_ff;
   assign push_item.abs_error = err5_ff;
   assign push_item.last      = last5_ff;
   assign push_item.step_err  = se5_ff;

`ifndef ASSERT_OFF
   a_code_in_range: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !cfg.step_zero |-> code3_ff <= cfg.levels - 1'b1)
      else $error("quantizer code above levels-1");
`endif

endmodule

`default_nettype wire

>>> sv/uqm_fifo.sv
// Short queue of quantized words between the front and back ends.
// Depends on uqm_pkg.
`default_nettype none

module uqm_fifo import uqm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  q_item_type push_item,
   output logic       full,
   input  logic       pop,
   output q_item_type head,
   output logic       empty
);

   q_item_type                mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0]  wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [FIFO_FILL_BITS-1:0] fill_ff, fill_in;

   assign full  = (fill_ff == FIFO_FILL_BITS'(FIFO_DEPTH));
   assign empty = (fill_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = (wr_ptr_ff == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      unique case ({push, pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (push) wr_ptr_ff <= wr_ptr_in;
         if (pop)  rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef ASSERT_OFF
   a_fill_tracks_push: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> fill_ff == $past(fill_ff) + 1'b1)
      else $error("fifo fill count did not follow a push");
`endif

endmodule

`default_nettype wire

>>> sv/uqm_back.sv
// Back end: squares the error, keeps max error, squared-error sum and pixel
// count, divides for MSE on the last pixel and holds the output register.
// Depends on uqm_pkg and uqm_rsp_if; drains uqm_fifo.
`default_nettype none

module uqm_back import uqm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  q_item_type head,
   input  logic       empty,
   output logic       pop,
   uqm_rsp_if.source  rsp_if
);

   logic                 b_valid_ff;
   q_item_type           b_item_ff;
   logic [SQ_BITS-1:0]   b_sq_ff, sq_in;

   logic [SUM_BITS-1:0]  sum_ff, sum_new;
   logic [SUM_BITS:0]    sum_wide;
   logic [CNT_W-1:0]     count_ff, count_new;
   logic [DATA_BITS-1:0] max_ff, max_new;

   logic                    div_busy_ff;
   logic [DIV_NUM_BITS-1:0] div_num_ff;
   logic [CNT_W-1:0]        div_rem_ff, div_den_ff, div_rem_in;
   logic [DIV_CNT_BITS-1:0] div_cnt_ff;
   logic [CNT_W:0]          shifted, diff;
   logic                    ge;
   logic [MSE_BITS-1:0]     mse_sat;

   rsp_type out_ff, hold_ff, c_result, done_result;
   logic    out_valid_ff, out_valid_in;
   logic    out_free, c_fire, adv_b, start_div, div_done;

   assign out_free  = !out_valid_ff || rsp_if.ready;
   assign c_fire    = b_valid_ff && out_free && !div_busy_ff;
   assign adv_b     = !b_valid_ff || c_fire;
   assign pop       = !empty && adv_b;
   assign start_div = c_fire && b_item_ff.last && !b_item_ff.step_err;
   assign div_done  = div_busy_ff && (div_cnt_ff == '0) && out_free;

   assign sq_in = SQ_BITS'(head.abs_error) * SQ_BITS'(head.abs_error);

   assign max_new   = (b_item_ff.abs_error > max_ff) ? b_item_ff.abs_error : max_ff;
   assign sum_wide  = {1'b0, sum_ff} + (SUM_BITS + 1)'(b_sq_ff);
   assign sum_new   = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
   assign count_new = count_ff[COUNT_BITS] ? count_ff : count_ff + 1'b1;

   // restoring division, one quotient bit per cycle
   assign shifted    = {div_rem_ff, div_num_ff[DIV_NUM_BITS-1]};
   assign ge         = (shifted >= {1'b0, div_den_ff});
   assign diff       = shifted - {1'b0, div_den_ff};
   assign div_rem_in = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
   assign mse_sat    = (div_num_ff[DIV_NUM_BITS-1:MSE_BITS] != '0) ? '1
                                                                   : div_num_ff[MSE_BITS-1:0];

   always_comb begin
      c_result = '0;
      if (b_item_ff.step_err) begin
         c_result.step_error = 1'b1;
      end else begin
         c_result.code          = b_item_ff.code;
         c_result.reconstructed = b_item_ff.recon;
         c_result.abs_error     = b_item_ff.abs_error;
         c_result.max_error     = max_new;
      end
   end

   always_comb begin
      done_result            = hold_ff;
      done_result.mse        = mse_sat;
      done_result.image_done = 1'b1;
   end

   always_comb begin
      if ((c_fire && !start_div) || div_done) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         div_busy_ff  <= 1'b0;
         sum_ff       <= '0;
         count_ff     <= '0;
         max_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (adv_b) b_valid_ff <= !empty;
         if (c_fire && !b_item_ff.step_err) begin
            if (b_item_ff.last) begin
               sum_ff      <= '0;
               count_ff    <= '0;
               max_ff      <= '0;
               div_busy_ff <= 1'b1;
            end else begin
               sum_ff   <= sum_new;
               count_ff <= count_new;
               max_ff   <= max_new;
            end
         end
         if (div_done) div_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b_item_ff <= head;
         b_sq_ff   <= sq_in;
      end
      if (start_div) begin
         hold_ff    <= c_result;
         div_num_ff <= {sum_new, {MSE_FRAC_BITS{1'b0}}};
         div_den_ff <= count_new;
         div_rem_ff <= '0;
         div_cnt_ff <= DIV_CNT_BITS'(DIV_NUM_BITS);
      end else if (div_busy_ff && div_cnt_ff != '0) begin
         div_num_ff <= {div_num_ff[DIV_NUM_BITS-2:0], ge};
         div_rem_ff <= div_rem_in;
         div_cnt_ff <= div_cnt_ff - 1'b1;
      end
      if (c_fire && !start_div) begin
         out_ff <= c_result;
      end else if (div_done) begin
         out_ff <= done_result;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.code          = out_ff.code;
   assign rsp_if.reconstructed = out_ff.reconstructed;
   assign rsp_if.abs_error     = out_ff.abs_error;
   assign rsp_if.max_error     = out_ff.max_error;
   assign rsp_if.mse           = out_ff.mse;
   assign rsp_if.image_done    = out_ff.image_done;
   assign rsp_if.step_error    = out_ff.step_error;

`ifndef ASSERT_OFF
   a_step_error_zeroed: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.step_error |->
         !out_ff.image_done && out_ff.mse == '0 && out_ff.max_error == '0)
      else $error("step error word carries nonzero statistics");
   a_last_clears_stats: assert property (@(posedge clock) disable iff (reset)
      start_div |=> div_busy_ff && count_ff == '0 && max_ff == '0 && sum_ff == '0)
      else $error("last pixel did not start mse division and clear statistics");
`endif

endmodule

`default_nettype wire

>>> sv/uniform_quantizer_with_mse.sv
// Uniform scalar quantizer with running error statistics.
// Channels: req_if carries pixel/last_pixel words in, rsp_if carries one
// result word per pixel out, csr_if writes max_scale (index 0) and levels
// (index 1); writes to other indexes are dropped. All use valid/ready.
// The front end quantizes with a reciprocal multiply in a 5-stage pipeline
// and takes one word per cycle while the queue has room and the config
// divider is idle. A 4-entry queue feeds the back end, which retires one
// word per cycle while rsp_if.ready is high; the last pixel of an image
// starts the serial MSE division (60 quotient bits at one per cycle),
// during which the queue and then req_if.ready back up.
// After reset and after every csr write, req_if.ready stays low while a
// serial divider derives the step and its reciprocal.
// Reset loads max_scale 255 and levels 10 and clears the statistics.
// When rsp_if.ready is low the result word holds in the output register and
// the block keeps accepting until the queue and pipeline fill.
// Depends on uqm_pkg, uqm_intf and the uqm_* submodules.
`default_nettype none

module uniform_quantizer_with_mse import uqm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   uqm_csr_if.sink    csr_if,
   uqm_req_if.sink    req_if,
   uqm_rsp_if.source  rsp_if
);

   cfg_type    cfg;
   logic       cfg_busy;
   logic       fifo_full, fifo_empty, push, pop;
   q_item_type push_item, head;

   uqm_cfg u_cfg (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg),
      .busy   (cfg_busy)
   );

   uqm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .cfg       (cfg),
      .cfg_busy  (cfg_busy),
      .fifo_full (fifo_full),
      .push      (push),
      .push_item (push_item)
   );

   uqm_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (fifo_full),
      .pop       (pop),
      .head      (head),
      .empty     (fifo_empty)
   );

   uqm_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .empty  (fifo_empty),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

endmodule

`default_nettype wire
